// ===== hdl/tbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_pkg - shared types and constants for the thread block dispatcher
// field widths, status and opcode codes, register map, controller interface
// ----------------------------------------------------------------------------
package tbd_pkg;

	// default sizing
	localparam int SM_COUNT_DEF   = 4;
	localparam int WARP_LANES_DEF = 32;

	// field and counter widths
	localparam int THR_W    = 12;
	localparam int SHR_W    = 18;
	localparam int REG_W    = 19;
	localparam int BPT_W    = 10;
	localparam int BR_W     = THR_W + BPT_W;
	localparam int WARP_W   = 7;
	localparam int STATUS_W = 2;
	localparam int SMID_W   = 2;

	localparam logic [WARP_W-1:0] WARP_MAX = '1;

	// opcodes
	localparam logic OP_SCHEDULE = 1'b0;
	localparam logic OP_RELEASE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CLAMP = 2'd2;

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 4;
	localparam logic [1:0] REG_THREAD_LIMIT = 2'd0;
	localparam logic [1:0] REG_SHARED_LIMIT = 2'd1;
	localparam logic [1:0] REG_REGBYTE_LIMIT = 2'd2;

	localparam logic [THR_W-1:0] THREAD_LIMIT_RST  = 12'd2048;
	localparam logic [SHR_W-1:0] SHARED_LIMIT_RST  = 18'd131072;
	localparam logic [REG_W-1:0] REGBYTE_LIMIT_RST = 19'd262144;

	typedef struct packed {
		logic [THR_W-1:0] thr;
		logic [SHR_W-1:0] shr;
		logic [REG_W-1:0] rgb;
	} limits_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_WRITE,
		S_REFUSE
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd;
		logic eval;
		logic next_sm;
		logic commit;
		logic refuse;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic release_op;
		logic target_ok;
		logic fits;
		logic last_sm;
	} sts_t;

endpackage

// ===== hdl/tbd_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_cfg - limit registers behind the apb port
// three per-multiprocessor limits, written in the access phase, read back
// ----------------------------------------------------------------------------
module tbd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tbd_pkg::PADDR_W-1:0]   paddr,
	input  logic [tbd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [tbd_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	output tbd_pkg::limits_t              limits
);
	import tbd_pkg::*;

	logic       wr_en;
	logic [1:0] reg_idx;
	limits_t    lim_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign limits  = lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.thr <= THREAD_LIMIT_RST;
			lim_q.shr <= SHARED_LIMIT_RST;
			lim_q.rgb <= REGBYTE_LIMIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_THREAD_LIMIT:  lim_q.thr <= pwdata[THR_W-1:0];
				REG_SHARED_LIMIT:  lim_q.shr <= pwdata[SHR_W-1:0];
				REG_REGBYTE_LIMIT: lim_q.rgb <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_THREAD_LIMIT:  prdata = APB_DATA_W'(lim_q.thr);
			REG_SHARED_LIMIT:  prdata = APB_DATA_W'(lim_q.shr);
			REG_REGBYTE_LIMIT: prdata = APB_DATA_W'(lim_q.rgb);
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== hdl/tbd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_ctrl - dispatch sequencer
// walks the multiprocessors one at a time and owns the result valid flag
// ----------------------------------------------------------------------------
module tbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          res_valid,
	input  logic          res_ready,
	input  tbd_pkg::sts_t sts,
	output tbd_pkg::cmd_t cmd
);
	import tbd_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        res_valid_q;
	logic        slot_free;
	logic        emit;

	assign slot_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		emit    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.release_op) begin
					cmd.eval = 1'b1;
					state_d  = sts.target_ok ? S_WRITE : S_REFUSE;
				end else if (sts.fits) begin
					cmd.eval = 1'b1;
					state_d  = S_WRITE;
				end else if (sts.last_sm) begin
					state_d = S_REFUSE;
				end else begin
					cmd.next_sm = 1'b1;
					state_d     = S_READ;
				end
			end
			S_WRITE: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					emit       = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_REFUSE: begin
				if (slot_free) begin
					cmd.refuse = 1'b1;
					emit       = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hdl/tbd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_dp - dispatcher datapath
// request registers, per-multiprocessor usage memory, fit test and warp count
// ----------------------------------------------------------------------------
module tbd_dp #(
	parameter int SM_COUNT   = tbd_pkg::SM_COUNT_DEF,
	parameter int WARP_LANES = tbd_pkg::WARP_LANES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tbd_pkg::cmd_t                  cmd,
	output tbd_pkg::sts_t                  sts,
	input  tbd_pkg::limits_t               limits,
	input  logic                           opcode,
	input  logic [tbd_pkg::SMID_W-1:0]     target_sm,
	input  logic [tbd_pkg::THR_W-1:0]      block_threads,
	input  logic [tbd_pkg::SHR_W-1:0]      block_shared_bytes,
	input  logic [tbd_pkg::BPT_W-1:0]      bytes_per_thread,
	output logic [tbd_pkg::STATUS_W-1:0]   status,
	output logic [tbd_pkg::SMID_W-1:0]     chosen_sm,
	output logic [tbd_pkg::WARP_W-1:0]     warps_now
);
	import tbd_pkg::*;

	localparam int SM_W  = (SM_COUNT > 1) ? $clog2(SM_COUNT) : 1;
	localparam int ENT_W = THR_W + SHR_W + REG_W + WARP_W;
	localparam logic [SM_W-1:0] LAST_SM = SM_W'(SM_COUNT - 1);
	// ceiling division by the warp width as a reciprocal multiply
	localparam int NUM_W   = THR_W + 1;
	localparam int RCP_SH  = NUM_W + 7;
	localparam int RCP_W   = RCP_SH + 1;
	localparam int PROD_W  = NUM_W + RCP_W;
	localparam int QUO_W   = PROD_W - RCP_SH;
	localparam int RCP_MUL = ((1 << RCP_SH) + WARP_LANES - 1) / WARP_LANES;

	// request registers
	logic              op_q;
	logic [SMID_W-1:0] target_q;
	logic [THR_W-1:0]  bt_q;
	logic [SHR_W-1:0]  bs_q;
	logic [BR_W-1:0]   br_q;
	logic [SM_W-1:0]   idx_q;
	logic [SM_W+SMID_W-1:0] tgt_ext;
	logic [SM_W+SMID_W-1:0] idx_ext;

	// usage memory
	logic [ENT_W-1:0]    mem [SM_COUNT];
	logic [SM_COUNT-1:0] valid_q;
	logic [ENT_W-1:0]    rdata_q;
	logic                rvalid_q;
	logic [THR_W-1:0]    cur_t;
	logic [SHR_W-1:0]    cur_s;
	logic [REG_W-1:0]    cur_r;

	// fit test and release
	logic [THR_W:0]    sum_t;
	logic [SHR_W:0]    sum_s;
	logic [BR_W:0]     sum_r;
	logic              fits;
	logic              clamp_t, clamp_s, clamp_r;
	logic [THR_W-1:0]  new_t;
	logic [SHR_W-1:0]  new_s;
	logic [REG_W-1:0]  new_r;
	logic [THR_W-1:0]  t_s2;
	logic [SHR_W-1:0]  s_s2;
	logic [REG_W-1:0]  r_s2;
	logic              clamp_s2;

	// warp count
	logic [NUM_W-1:0]  warp_num;
	logic [PROD_W-1:0] warp_prod;
	logic [QUO_W-1:0]  warp_quo;
	logic [WARP_W-1:0] warps;

	logic [STATUS_W-1:0] status_q;
	logic [SMID_W-1:0]   chosen_q;
	logic [WARP_W-1:0]   warps_q;

	assign tgt_ext = (SM_W + SMID_W)'(target_sm);
	assign idx_ext = (SM_W + SMID_W)'(idx_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= opcode;
			target_q <= target_sm;
			bt_q     <= block_threads;
			bs_q     <= block_shared_bytes;
			br_q     <= BR_W'(block_threads) * BR_W'(bytes_per_thread);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			idx_q <= (opcode == OP_RELEASE) ? tgt_ext[SM_W-1:0] : '0;
		else if (cmd.next_sm)
			idx_q <= idx_q + SM_W'(1);
	end

	// memory ports: one read or one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.rd)
			rdata_q <= mem[idx_q];
		if (cmd.commit)
			mem[idx_q] <= {t_s2, s_s2, r_s2, warps};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (cmd.rd)
				rvalid_q <= valid_q[idx_q];
			if (cmd.commit)
				valid_q[idx_q] <= 1'b1;
		end
	end

	// never-written entries read as zero usage
	assign cur_t = rvalid_q ? rdata_q[ENT_W-1 -: THR_W] : '0;
	assign cur_s = rvalid_q ? rdata_q[ENT_W-THR_W-1 -: SHR_W] : '0;
	assign cur_r = rvalid_q ? rdata_q[WARP_W +: REG_W] : '0;

	always_comb begin
		sum_t = {1'b0, cur_t} + {1'b0, bt_q};
		sum_s = {1'b0, cur_s} + {1'b0, bs_q};
		sum_r = (BR_W + 1)'(cur_r) + {1'b0, br_q};
		fits  = (sum_t <= {1'b0, limits.thr}) &&
			(sum_s <= {1'b0, limits.shr}) &&
			(sum_r <= (BR_W + 1)'(limits.rgb));
		clamp_t = bt_q > cur_t;
		clamp_s = bs_q > cur_s;
		clamp_r = br_q > BR_W'(cur_r);
		if (op_q == OP_RELEASE) begin
			new_t = clamp_t ? '0 : cur_t - bt_q;
			new_s = clamp_s ? '0 : cur_s - bs_q;
			new_r = clamp_r ? '0 : cur_r - br_q[REG_W-1:0];
		end else begin
			new_t = sum_t[THR_W-1:0];
			new_s = sum_s[SHR_W-1:0];
			new_r = sum_r[REG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			t_s2     <= new_t;
			s_s2     <= new_s;
			r_s2     <= new_r;
			clamp_s2 <= clamp_t | clamp_s | clamp_r;
		end
	end

	always_comb begin
		warp_num  = NUM_W'(t_s2) + NUM_W'(WARP_LANES - 1);
		warp_prod = PROD_W'(warp_num) * PROD_W'(RCP_MUL);
		warp_quo  = warp_prod[PROD_W-1:RCP_SH];
		warps     = (warp_quo > QUO_W'(WARP_MAX)) ? WARP_MAX : warp_quo[WARP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= (op_q == OP_RELEASE && clamp_s2) ? ST_CLAMP : ST_DONE;
			chosen_q <= idx_ext[SMID_W-1:0];
			warps_q  <= warps;
		end else if (cmd.refuse) begin
			status_q <= ST_NOFIT;
			chosen_q <= (op_q == OP_RELEASE) ? target_q : '0;
			warps_q  <= '0;
		end
	end

	assign status    = status_q;
	assign chosen_sm = chosen_q;
	assign warps_now = warps_q;

	assign sts.release_op = (op_q == OP_RELEASE);
	assign sts.target_ok  = (32'(target_q) < 32'(SM_COUNT));
	assign sts.fits       = fits;
	assign sts.last_sm    = (idx_q == LAST_SM);

endmodule

// ===== hdl/thread_block_first_fit_dispatcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_block_first_fit_dispatcher - first-fit thread block placement
// places blocks on the lowest multiprocessor with room, releases them on request
// ----------------------------------------------------------------------------
// requests: one at a time; a new one is taken only after the last result is issued,
//   and a result held back by res_ready stalls the sequencer before it is issued
// fit test: each multiprocessor takes one read of the usage memory, then a compare
// reset: limits return to 2048 threads, 128 KiB shared, 256 KiB registers; all
//   usage reads as zero at once through per-entry valid bits, no clearing pass
module thread_block_first_fit_dispatcher #(
	parameter int SM_COUNT   = tbd_pkg::SM_COUNT_DEF,
	parameter int WARP_LANES = tbd_pkg::WARP_LANES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tbd_pkg::PADDR_W-1:0]    paddr,
	input  logic [tbd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [tbd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	// request channel
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic                           opcode,
	input  logic [tbd_pkg::SMID_W-1:0]     target_sm,
	input  logic [tbd_pkg::THR_W-1:0]      block_threads,
	input  logic [tbd_pkg::SHR_W-1:0]      block_shared_bytes,
	input  logic [tbd_pkg::BPT_W-1:0]      bytes_per_thread,
	// result channel
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [tbd_pkg::STATUS_W-1:0]   status,
	output logic [tbd_pkg::SMID_W-1:0]     chosen_sm,
	output logic [tbd_pkg::WARP_W-1:0]     warps_now
);
	import tbd_pkg::*;

	limits_t limits;
	cmd_t    cmd;
	sts_t    sts;

	// limit registers; the user must rewrite them only while no request is in flight, the block does not enforce this
	tbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limits  (limits)
	);

	// sequencer: accept, read each candidate entry, test, write back or refuse, report
	tbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// usage memory, fit test, saturating release and warp count
	tbd_dp #(
		.SM_COUNT   (SM_COUNT),
		.WARP_LANES (WARP_LANES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.limits             (limits),
		.opcode             (opcode),
		.target_sm          (target_sm),
		.block_threads      (block_threads),
		.block_shared_bytes (block_shared_bytes),
		.bytes_per_thread   (bytes_per_thread),
		.status             (status),
		.chosen_sm          (chosen_sm),
		.warps_now          (warps_now)
	);

endmodule
